// ----- rtl/rde_pkg.sv -----
// Shared constants and controller/datapath interface types for the radix digit emitter.
`timescale 1ns / 1ps

package rde_pkg;

    localparam int DEF_VALUE_BITS = 64;
    localparam int DEF_MAX_RADIX  = 16;

    // Dividend bits consumed per divider cycle
    localparam int STEP_BITS = 8;

    localparam int DIGIT_W = 4;
    localparam int COUNT_W = 7;
    localparam int CHAR_W  = 8;
    localparam int RADIX_W = 5;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_RADIX    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARS_LO = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARS_HI = 2'd2;

    localparam logic [RADIX_W-1:0] RESET_RADIX    = 5'd10;
    localparam logic [63:0]        RESET_CHARS_LO = 64'h3736353433323130;
    localparam logic [63:0]        RESET_CHARS_HI = 64'h6665646362613938;

    typedef struct packed {
        logic               start;     // load dividend from the input transaction
        logic               step;      // advance the divider over the next dividend byte
        logic               wr_digit;  // store remainder as next digit
        logic               rd;        // read digit store
        logic               out_load;  // load output register from read data
        logic               out_last;
        logic [COUNT_W-1:0] count;
    } rde_cmd_t;

    typedef struct packed {
        logic quot_zero;
        logic out_fire;
    } rde_status_t;

endpackage

// ----- rtl/rde_ctrl.sv -----
// Sequencer for the radix digit emitter: division passes, then digit emission.
`timescale 1ns / 1ps

module rde_ctrl import rde_pkg::*; #(
    parameter int VALUE_BITS = DEF_VALUE_BITS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    output rde_cmd_t                        cmd,
    output logic [$clog2(VALUE_BITS)-1:0]   addr,
    input  rde_status_t                     status
);

    localparam int AW     = $clog2(VALUE_BITS);
    localparam int NCHUNK = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
    localparam int CW     = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_WR   = 3'd2;
    localparam logic [2:0] ST_RD   = 3'd3;
    localparam logic [2:0] ST_LOAD = 3'd4;
    localparam logic [2:0] ST_HOLD = 3'd5;

    logic [2:0]         state_reg, state_next;
    logic [CW-1:0]      chunk_reg, chunk_next;
    logic [COUNT_W-1:0] ndig_reg, ndig_next;
    logic [COUNT_W-1:0] cnt_reg, cnt_next;
    logic [AW-1:0]      idx_reg, idx_next;
    logic [COUNT_W-1:0] ndig_inc;

    assign ndig_inc = ndig_reg + COUNT_W'(1);
    assign s_tready = (state_reg == ST_IDLE);
    assign addr     = (state_reg == ST_WR) ? ndig_reg[AW-1:0] : idx_reg;

    always_comb begin
        state_next = state_reg;
        chunk_next = chunk_reg;
        ndig_next  = ndig_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        cmd.count  = cnt_reg;
        cmd.out_last = (idx_reg == '0);
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.start  = 1'b1;
                    chunk_next = '0;
                    ndig_next  = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.step = 1'b1;
                if (chunk_reg == CW'(NCHUNK - 1)) begin
                    state_next = ST_WR;
                end else begin
                    chunk_next = chunk_reg + CW'(1);
                end
            end
            ST_WR: begin
                cmd.wr_digit = 1'b1;
                ndig_next    = ndig_inc;
                chunk_next   = '0;
                if (status.quot_zero || ndig_inc == COUNT_W'(VALUE_BITS)) begin
                    // emit from the most significant digit, stored last
                    idx_next   = ndig_reg[AW-1:0];
                    cnt_next   = ndig_inc;
                    state_next = ST_RD;
                end else begin
                    state_next = ST_DIV;
                end
            end
            ST_RD: begin
                cmd.rd     = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                cmd.out_load = 1'b1;
                state_next   = ST_HOLD;
            end
            ST_HOLD: begin
                if (status.out_fire) begin
                    if (idx_reg == '0) begin
                        state_next = ST_IDLE;
                    end else begin
                        idx_next   = idx_reg - AW'(1);
                        state_next = ST_RD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            chunk_reg <= '0;
            ndig_reg  <= '0;
            cnt_reg   <= '0;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            chunk_reg <= chunk_next;
            ndig_reg  <= ndig_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

// ----- rtl/rde_datapath.sv -----
// Datapath: config registers, radix divider, digit store and output register.
`timescale 1ns / 1ps

module rde_datapath import rde_pkg::*; #(
    parameter int VALUE_BITS = DEF_VALUE_BITS,
    parameter int MAX_RADIX  = DEF_MAX_RADIX
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    input  logic [CFG_IDX_W-1:0]            cfg_index,
    input  logic [63:0]                     cfg_data,
    input  logic [63:0]                     s_value,
    input  rde_cmd_t                        cmd,
    input  logic [$clog2(VALUE_BITS)-1:0]   addr,
    output rde_status_t                     status,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [15:0]                     m_tdata,
    output logic                            m_tlast
);

    localparam int AW     = $clog2(VALUE_BITS);
    localparam int DEPTH  = VALUE_BITS;
    localparam int NCHUNK = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
    localparam int W      = NCHUNK * STEP_BITS;

    logic [RADIX_W-1:0] radix_reg;
    logic [63:0]        chars_lo_reg;
    logic [63:0]        chars_hi_reg;
    logic [RADIX_W-1:0] eff_radix;

    logic [W-1:0]         work_reg, work_next;
    logic [DIGIT_W-1:0]   rem_reg, rem_next;
    logic [STEP_BITS-1:0] qbits;

    logic [DIGIT_W-1:0] digit_mem [DEPTH];
    logic [DIGIT_W-1:0] rd_data_reg;
    logic [CHAR_W-1:0]  char_sel;

    logic               out_valid_reg;
    logic [CHAR_W-1:0]  out_char_reg;
    logic [COUNT_W-1:0] out_count_reg;
    logic               out_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg    <= RESET_RADIX;
            chars_lo_reg <= RESET_CHARS_LO;
            chars_hi_reg <= RESET_CHARS_HI;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_RADIX:    radix_reg    <= cfg_data[RADIX_W-1:0];
                CFG_CHARS_LO: chars_lo_reg <= cfg_data;
                CFG_CHARS_HI: chars_hi_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (radix_reg < RADIX_W'(2)) begin
            eff_radix = RADIX_W'(2);
        end else if (radix_reg > RADIX_W'(MAX_RADIX)) begin
            eff_radix = RADIX_W'(MAX_RADIX);
        end else begin
            eff_radix = radix_reg;
        end
    end

    // Long division of the top byte by the radix, one restoring step per bit
    always_comb begin
        logic [RADIX_W-1:0]   trial;
        logic [STEP_BITS-1:0] top;
        top      = work_reg[W-1 -: STEP_BITS];
        rem_next = rem_reg;
        qbits    = '0;
        for (int i = STEP_BITS - 1; i >= 0; i--) begin
            trial = {rem_next, top[i]};
            if (trial >= eff_radix) begin
                qbits[i] = 1'b1;
                rem_next = DIGIT_W'(trial - eff_radix);
            end else begin
                rem_next = trial[DIGIT_W-1:0];
            end
        end
        work_next = (work_reg << STEP_BITS) | W'(qbits);
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            work_reg <= W'(s_value[VALUE_BITS-1:0]);
        end else if (cmd.step) begin
            work_reg <= work_next;
        end
        if (cmd.start || cmd.wr_digit) begin
            rem_reg <= '0;
        end else if (cmd.step) begin
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr_digit) begin
            digit_mem[addr] <= rem_reg;
        end
        if (cmd.rd) begin
            rd_data_reg <= digit_mem[addr];
        end
    end

    always_comb begin
        if (rd_data_reg[3]) begin
            char_sel = chars_hi_reg[rd_data_reg[2:0]*CHAR_W +: CHAR_W];
        end else begin
            char_sel = chars_lo_reg[rd_data_reg[2:0]*CHAR_W +: CHAR_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_char_reg  <= char_sel;
            out_count_reg <= cmd.count;
            out_last_reg  <= cmd.out_last;
        end
    end

    assign status.quot_zero = (work_reg == '0);
    assign status.out_fire  = out_valid_reg && m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_count_reg, out_char_reg};
    assign m_tlast  = out_last_reg;

endmodule

// ----- rtl/radix_digit_emitter_unit.sv -----
// Top level of the radix digit emitter: unsigned value to radix digit characters.
//
//  channel | direction | handshake                    | payload
//  s_      | in        | s_tvalid / s_tready          | s_tdata[63:0] value
//  m_      | out       | m_tvalid / m_tready          | m_tdata char, count; m_tlast
//  cfg_    | in        | cfg_valid / cfg_ready (high) | cfg_index register, cfg_data
//
// One transaction in gives D digit transactions out, D = digits of the value.
// Each digit is found by a divider pass over the value (8 dividend bits per cycle),
// then stored; the digits are then read, loaded and held for output, one at a time.
// Reset clears config to radix 10, table "0123456789abcdef", and the sequencer.
// The digit store needs no clearing: every entry is written before it is read.
// A stall on m_tready holds the current digit; the input waits until the last digit goes.
`timescale 1ns / 1ps

module radix_digit_emitter_unit import rde_pkg::*; #(
    parameter int VALUE_BITS = DEF_VALUE_BITS,
    parameter int MAX_RADIX  = DEF_MAX_RADIX
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [63:0]           s_tdata,   // [63:0] value
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [15:0]           m_tdata,   // [7:0] digit_char, [14:8] digit_count, [15] 0
    output logic                  m_tlast,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [63:0]           cfg_data
);

    localparam int AW = $clog2(VALUE_BITS);

    rde_cmd_t    cmd;
    rde_status_t status;
    logic [AW-1:0] addr;

    assign cfg_ready = 1'b1;

    rde_ctrl #(
        .VALUE_BITS(VALUE_BITS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .cmd     (cmd),
        .addr    (addr),
        .status  (status)
    );

    rde_datapath #(
        .VALUE_BITS(VALUE_BITS),
        .MAX_RADIX (MAX_RADIX)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_value  (s_tdata),
        .cmd      (cmd),
        .addr     (addr),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // no new value while a digit is still pending
    a_no_accept_while_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |-> !m_tvalid)
        else $error("input accepted while a digit is pending");

    // output register is never reloaded over an untaken digit
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !m_tvalid)
        else $error("output register overwritten");

    // after the final digit the block is ready for the next value
    a_ready_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> s_tready)
        else $error("not ready after last digit");

    // every emitted digit carries a count of at least one
    a_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[14:8] != 7'd0))
        else $error("digit count is zero");

endmodule
